// ===== hdl/pwmfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwmfs_pkg
// Shared types and constants for the four-channel pwm fade sequencer:
// register map, field widths and register reset values.
// ----------------------------------------------------------------------------
package pwmfs_pkg;

    localparam int PRESCALE_W = 16;
    localparam int PERIOD_W   = 16;
    localparam int DUTY_W     = 16;
    localparam int HOLD_W     = 32;

    localparam int PWM_OUT_W  = 4;
    localparam int ACT_CH_W   = 2;
    localparam int LEVEL_W    = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd3599;
    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 16'd99;
    localparam logic [DUTY_W-1:0]     DUTY_RESET     = 16'd100;
    localparam logic [HOLD_W-1:0]     HOLD_RESET     = 32'd200;

    typedef enum logic [1:0] {
        REG_PRESCALE_DIV = 2'd0,
        REG_PERIOD_TOP   = 2'd1,
        REG_DUTY_MAX     = 2'd2,
        REG_FADE_HOLD    = 2'd3
    } cfg_reg_t;

endpackage : pwmfs_pkg
`default_nettype wire

// ===== hdl/four_channel_pwm_fade_sequencer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// four_channel_pwm_fade_sequencer_top
// Edge-aligned pwm with prescaler, period counter and a breathing fade
// sequencer that ramps each channel's compare up and down in turn.
// ----------------------------------------------------------------------------
// a request passes the input register, then the result register;
//   throughput: one request per cycle while out_stall is low
// the timer state is updated in the same cycle the result register loads
// rst_n (async, active low) clears all counters, compares, channel, direction
//   and loads the registers with their documented reset values
module four_channel_pwm_fade_sequencer_top
    import pwmfs_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  tick_enable,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PWM_OUT_W-1:0]       pwm_out,
    output logic [ACT_CH_W-1:0]        active_channel,
    output logic [LEVEL_W-1:0]         duty_level,
    output logic                       fade_down,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    // configuration registers
    logic [PRESCALE_W-1:0] prescale_div_reg;
    logic [PERIOD_W-1:0]   period_top_reg;
    logic [DUTY_W-1:0]     duty_max_reg;
    logic [HOLD_W-1:0]     fade_hold_reg;

    // input register
    logic in_valid_reg;
    logic in_tick_reg;

    // timer state
    logic [COUNT_WIDTH-1:0] prescale_count_reg, prescale_count_next;
    logic [COUNT_WIDTH-1:0] period_count_reg, period_count_next;
    logic [HOLD_W-1:0]      hold_count_reg, hold_count_next;
    logic [COUNT_WIDTH-1:0] compare_reg  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] compare_next [NUM_CHANNELS];
    logic [CH_W-1:0]        channel_reg, channel_next;
    logic                   dir_reg, dir_next;

    // result register
    logic                 out_valid_reg;
    logic [PWM_OUT_W-1:0] pwm_out_reg;
    logic [ACT_CH_W-1:0]  active_channel_reg;
    logic [LEVEL_W-1:0]   duty_level_reg;
    logic                 fade_down_reg;

    logic                   advance;
    logic                   process;
    logic                   cfg_write;
    cfg_reg_t               cfg_sel;
    logic [COUNT_WIDTH-1:0] prescale_top;
    logic [COUNT_WIDTH-1:0] period_top;
    logic [COUNT_WIDTH-1:0] level_top;
    logic [HOLD_W-1:0]      hold_last;
    logic                   prescale_wrap;
    logic                   level_step;
    logic [COUNT_WIDTH-1:0] cur_level;
    logic [COUNT_WIDTH-1:0] new_level;
    logic [CH_W-1:0]        wrap_channel;
    logic                   channel_move;
    logic [PWM_OUT_W-1:0]   pwm_next;

    // ------------------------------------------------------------------
    // apb register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_div_reg <= PRESCALE_RESET;
            period_top_reg   <= PERIOD_RESET;
            duty_max_reg     <= DUTY_RESET;
            fade_hold_reg    <= HOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_PRESCALE_DIV: prescale_div_reg <= pwdata[PRESCALE_W-1:0];
                REG_PERIOD_TOP:   period_top_reg   <= pwdata[PERIOD_W-1:0];
                REG_DUTY_MAX:     duty_max_reg     <= pwdata[DUTY_W-1:0];
                REG_FADE_HOLD:    fade_hold_reg    <= pwdata[HOLD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_PRESCALE_DIV: prdata = APB_DATA_W'(prescale_div_reg);
            REG_PERIOD_TOP:   prdata = APB_DATA_W'(period_top_reg);
            REG_DUTY_MAX:     prdata = APB_DATA_W'(duty_max_reg);
            REG_FADE_HOLD:    prdata = APB_DATA_W'(fade_hold_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign process  = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_tick_reg <= tick_enable;
        end
    end

    // ------------------------------------------------------------------
    // timer and fade sequencer next state
    // ------------------------------------------------------------------
    assign prescale_top = COUNT_WIDTH'(prescale_div_reg);
    assign period_top   = COUNT_WIDTH'(period_top_reg);
    assign level_top    = COUNT_WIDTH'(duty_max_reg);
    // zero hold behaves as one
    assign hold_last    = (fade_hold_reg == '0) ? '0 : fade_hold_reg - 1'b1;

    assign prescale_wrap = in_tick_reg && (prescale_count_reg >= prescale_top);
    assign level_step    = prescale_wrap && (hold_count_reg >= hold_last);
    assign cur_level     = compare_reg[channel_reg];
    assign wrap_channel  = (channel_reg == LAST_CH) ? '0 : channel_reg + 1'b1;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        period_count_next   = period_count_reg;
        hold_count_next     = hold_count_reg;
        channel_next        = channel_reg;
        dir_next            = dir_reg;
        new_level           = cur_level;
        channel_move        = 1'b0;

        if (in_tick_reg)
        begin
            prescale_count_next = prescale_wrap ? '0 : prescale_count_reg + 1'b1;
        end

        if (prescale_wrap)
        begin
            period_count_next = (period_count_reg >= period_top) ? '0
                                                                 : period_count_reg + 1'b1;
            hold_count_next   = level_step ? '0 : hold_count_reg + 1'b1;
        end

        if (level_step)
        begin
            if (!dir_reg)
            begin
                if (cur_level < level_top)
                begin
                    new_level = cur_level + 1'b1;
                end
                else
                begin
                    // clamp to the top and turn around
                    new_level = level_top;
                    dir_next  = 1'b1;
                end
            end
            else
            begin
                if (cur_level != '0)
                begin
                    new_level = cur_level - 1'b1;
                end
                else
                begin
                    // bottom reached: hand over to the next channel
                    new_level    = '0;
                    channel_move = 1'b1;
                    channel_next = wrap_channel;
                    dir_next     = 1'b0;
                end
            end
        end

        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            compare_next[i] = compare_reg[i];
            if (level_step && (CH_W'(i) == channel_next))
            begin
                compare_next[i] = new_level;
            end
        end
    end

    for (genvar g = 0; g < PWM_OUT_W; g++)
    begin : g_pwm
        if (g < NUM_CHANNELS)
        begin : g_live
            assign pwm_next[g] = period_count_next < compare_next[g];
        end
        else
        begin : g_absent
            assign pwm_next[g] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            period_count_reg   <= '0;
            hold_count_reg     <= '0;
            channel_reg        <= '0;
            dir_reg            <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                compare_reg[i] <= '0;
            end
        end
        else if (process)
        begin
            prescale_count_reg <= prescale_count_next;
            period_count_reg   <= period_count_next;
            hold_count_reg     <= hold_count_next;
            channel_reg        <= channel_next;
            dir_reg            <= dir_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                compare_reg[i] <= compare_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            pwm_out_reg        <= pwm_next;
            active_channel_reg <= ACT_CH_W'(channel_next);
            duty_level_reg     <= LEVEL_W'(new_level);
            fade_down_reg      <= dir_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pwm_out        = pwm_out_reg;
    assign active_channel = active_channel_reg;
    assign duty_level     = duty_level_reg;
    assign fade_down      = fade_down_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        channel_reg <= LAST_CH)
        else $error("active channel out of range");

    a_stalled_request_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg)
        else $error("stalled request dropped from input register");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> out_valid_reg)
        else $error("processed request produced no result");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (process && !in_tick_reg) |=>
            ($stable(prescale_count_reg) && $stable(period_count_reg)
             && $stable(hold_count_reg) && $stable(channel_reg)))
        else $error("timer state moved without tick");

    a_move_resets_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (process && channel_move) |=> !dir_reg)
        else $error("channel handover did not restart ramp up");

endmodule : four_channel_pwm_fade_sequencer_top
`default_nettype wire

// ===== verif/four_channel_pwm_fade_sequencer_top_test.sv =====
// ----------------------------------------------------------------------------
// four_channel_pwm_fade_sequencer_top_test
// Self-checking bench for the pwm fade sequencer. Random tick requests run
// under several register settings. A scoreboard class predicts prescaler,
// period counter, hold counter and fade ramp, then checks every result
// field by field. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module four_channel_pwm_fade_sequencer_top_test;
    import pwmfs_pkg::*;

    localparam int NCH         = 4;
    localparam int GAP_MAX     = 11;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [PWM_OUT_W-1:0] pwm;
        logic [ACT_CH_W-1:0]  channel;
        logic [LEVEL_W-1:0]   level;
        logic                 down;
    } pwm_sample_t;

    class pwm_fade_scoreboard;
        logic [PRESCALE_W-1:0] prescale_div;
        logic [PERIOD_W-1:0]   period_top;
        logic [DUTY_W-1:0]     duty_max;
        logic [HOLD_W-1:0]     fade_hold;

        logic [PRESCALE_W-1:0] prescale_cnt;
        logic [PERIOD_W-1:0]   period_cnt;
        logic [HOLD_W-1:0]     hold_cnt;
        logic [LEVEL_W-1:0]    compare [NCH];
        logic [ACT_CH_W-1:0]   channel;
        logic                  ramp_down;

        pwm_sample_t expected_samples [$];
        int          errors;

        function new();
            prescale_div = PRESCALE_RESET;
            period_top   = PERIOD_RESET;
            duty_max     = DUTY_RESET;
            fade_hold    = HOLD_RESET;
            prescale_cnt = '0;
            period_cnt   = '0;
            hold_cnt     = '0;
            foreach (compare[i]) compare[i] = '0;
            channel      = '0;
            ramp_down    = 1'b0;
            errors       = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [APB_DATA_W-1:0] val);
            case (idx)
                REG_PRESCALE_DIV: prescale_div = val[PRESCALE_W-1:0];
                REG_PERIOD_TOP:   period_top   = val[PERIOD_W-1:0];
                REG_DUTY_MAX:     duty_max     = val[DUTY_W-1:0];
                REG_FADE_HOLD:    fade_hold    = val[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void report(string msg);
            if (errors < REPORT_MAX) $display("%0t: %s", $realtime, msg);
            errors++;
        endfunction

        // advance the timer by one accepted tick request and queue its result
        function void note_tick(logic en);
            logic [HOLD_W:0] hold_lim;
            pwm_sample_t     s;
            if (en) begin
                if (prescale_cnt >= prescale_div) begin
                    prescale_cnt = '0;
                    period_cnt = (period_cnt >= period_top) ? '0 : period_cnt + 1'b1;
                    // a hold of zero acts as one
                    hold_lim = (fade_hold == '0) ? 1 : {1'b0, fade_hold};
                    if ({1'b0, hold_cnt} + 1'b1 >= hold_lim) begin
                        hold_cnt = '0;
                        if (!ramp_down) begin
                            if (compare[channel] < duty_max) begin
                                compare[channel] = compare[channel] + 1'b1;
                            end
                            else begin
                                // clamp also catches a level left above a lowered top
                                compare[channel] = duty_max;
                                ramp_down = 1'b1;
                            end
                        end
                        else if (compare[channel] != '0) begin
                            compare[channel] = compare[channel] - 1'b1;
                        end
                        else begin
                            channel = channel + 1'b1;
                            compare[channel] = '0;
                            ramp_down = 1'b0;
                        end
                    end
                    else begin
                        hold_cnt = hold_cnt + 1'b1;
                    end
                end
                else begin
                    prescale_cnt = prescale_cnt + 1'b1;
                end
            end
            s.pwm = '0;
            for (int i = 0; i < NCH; i++) s.pwm[i] = (period_cnt < compare[i]);
            s.channel = channel;
            s.level   = compare[channel];
            s.down    = ramp_down;
            expected_samples.push_back(s);
        endfunction

        function void check_result(pwm_sample_t got);
            pwm_sample_t exp_s;
            if (expected_samples.size() == 0) begin
                report($sformatf("result with nothing pending: pwm=%h ch=%0d lvl=%0d dn=%0b",
                                 got.pwm, got.channel, got.level, got.down));
                return;
            end
            exp_s = expected_samples.pop_front();
            if (got.pwm !== exp_s.pwm || got.channel !== exp_s.channel ||
                got.level !== exp_s.level || got.down !== exp_s.down) begin
                report($sformatf("exp pwm=%h ch=%0d lvl=%0d dn=%0b, got pwm=%h ch=%0d lvl=%0d dn=%0b",
                                 exp_s.pwm, exp_s.channel, exp_s.level, exp_s.down,
                                 got.pwm, got.channel, got.level, got.down));
            end
        endfunction
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  tick_enable = 1'b0;
    logic                  out_stall   = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic [PWM_OUT_W-1:0]  pwm_out;
    logic [ACT_CH_W-1:0]   active_channel;
    logic [LEVEL_W-1:0]    duty_level;
    logic                  fade_down;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pwm_fade_scoreboard fade_sb;
    bit tx_busy     = 1'b0;
    bit rx_busy     = 1'b0;
    int rx_hold_off = 0;
    int cycle_count = 0;

    four_channel_pwm_fade_sequencer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .tick_enable    (tick_enable),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pwm_out        (pwm_out),
        .active_channel (active_channel),
        .duty_level     (duty_level),
        .fade_down      (fade_down),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_gap(bit busy);
        return busy ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // result side: check accepted results, then pick the stall for the next cycle
    initial
    begin : result_sink
        int          stall_left;
        pwm_sample_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            begin
                got.pwm     = pwm_out;
                got.channel = active_channel;
                got.level   = duty_level;
                got.down    = fade_down;
                fade_sb.check_result(got);
                stall_left = draw_gap(rx_busy);
            end
            if (rx_hold_off > 0)
            begin
                rx_hold_off--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [APB_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fade_sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [APB_DATA_W-1:0] pre, input logic [APB_DATA_W-1:0] top,
                             input logic [APB_DATA_W-1:0] duty, input logic [APB_DATA_W-1:0] hold);
        write_reg(REG_PRESCALE_DIV, pre);
        write_reg(REG_PERIOD_TOP, top);
        write_reg(REG_DUTY_MAX, duty);
        write_reg(REG_FADE_HOLD, hold);
    endtask

    task automatic send_tick(input logic en);
        int gap;
        gap = draw_gap(tx_busy);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        tick_enable <= en;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        fade_sb.note_tick(en);
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (fade_sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int pct_enable, input bit flood);
        if (flood)
        begin
            // long result hold-off while requests keep coming
            tx_busy     = 1'b1;
            rx_busy     = 1'b0;
            rx_hold_off = 300;
        end
        else
        begin
            tx_busy = ($urandom_range(0, 2) == 0);
            rx_busy = ($urandom_range(0, 2) == 0);
        end
        for (int i = 0; i < n; i++)
            send_tick($urandom_range(0, 99) < pct_enable);
        drain();
    endtask

    initial
    begin
        fade_sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: prescaler only creeps
        for (int i = 0; i < 6; i++)
            send_tick(i[0]);
        drain();

        // zero hold with no prescale: one level per tick through top and bottom turns
        configure(0, 3, 2, 0);
        for (int i = 0; i < 16; i++)
            send_tick(1'b1);
        drain();

        configure(0, 3, 3, 1);
        run_phase(200, 85, 1'b0);
        configure(1, 5, 4, 2);
        run_phase(150, 85, 1'b0);

        // widest settings, then counters left beyond lowered tops
        configure(0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_phase(80, 100, 1'b0);
        write_reg(REG_PRESCALE_DIV, 16'hFFFF);
        run_phase(40, 100, 1'b0);
        write_reg(REG_PRESCALE_DIV, 1);
        write_reg(REG_PERIOD_TOP, 4);
        write_reg(REG_FADE_HOLD, 3);
        run_phase(150, 90, 1'b0);
        // level now above the new top while ramping up
        write_reg(REG_DUTY_MAX, 5);
        run_phase(200, 85, 1'b0);

        configure(0, 7, 6, 1);
        run_phase(150, 90, 1'b1);
        run_phase(150, 90, 1'b0);

        configure(0, 0, 0, 1);
        run_phase(100, 80, 1'b0);
        configure(0, 2, 1, 1);
        run_phase(150, 85, 1'b0);

        for (int p = 0; p < 3; p++)
        begin
            configure($urandom_range(0, 2), $urandom_range(0, 9),
                      $urandom_range(0, 6), $urandom_range(0, 3));
            run_phase(60, 85, 1'b0);
        end

        drain();
        repeat (10) @(posedge clk);
        if (fade_sb.errors == 0 && fade_sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
